### src/dcv_pkg.sv
`default_nettype none

package dcv_pkg;

    // defaults for the top level parameters
    localparam int ITERATIONS_DEF      = 15;
    localparam int DATA_WIDTH_DEF      = 16;
    localparam int ANGLE_FRAC_BITS_DEF = 13;

    // port widths fixed by the interface
    localparam int PORT_W  = 16;
    localparam int ANGLE_W = 16;

    // arctangent table: floor(atan(2^-i) * 2^ROM_FRAC)
    localparam int ROM_DEPTH = 16;
    localparam int ROM_FRAC  = 16;
    localparam int ROM_AW    = $clog2(ROM_DEPTH);

    localparam logic [15:0] ATAN_ROM [ROM_DEPTH] = '{
        16'd51471, 16'd30385, 16'd16054, 16'd8149,
        16'd4090,  16'd2047,  16'd1023,  16'd511,
        16'd255,   16'd127,   16'd63,    16'd31,
        16'd15,    16'd7,     16'd3,     16'd1
    };

    // table entry rounded to nearest at the chosen number of fraction bits
    function automatic logic [ANGLE_W-1:0] atan_const(input int idx, input int frac);
        int          sh;
        logic [31:0] t;
        sh = ROM_FRAC - frac;
        t  = 32'(ATAN_ROM[idx[ROM_AW-1:0]]);
        t  = (t + (32'd1 << (sh - 1))) >> sh;
        return t[ANGLE_W-1:0];
    endfunction

endpackage

`default_nettype wire

### src/dcv_stage.sv
`default_nettype none

module dcv_stage import dcv_pkg::*; #(
    parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
    parameter int SHIFT           = 0,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_valid,
    input  wire logic [1:0][DATA_WIDTH-1:0]       i_x,
    input  wire logic [1:0][DATA_WIDTH-1:0]       i_y,
    input  wire logic [1:0][ANGLE_W-1:0]          i_z,
    output logic                                  o_valid,
    output logic      [1:0][DATA_WIDTH-1:0]       o_x,
    output logic      [1:0][DATA_WIDTH-1:0]       o_y,
    output logic      [1:0][ANGLE_W-1:0]          o_z
);

    localparam logic [ANGLE_W-1:0] K = atan_const(SHIFT, ANGLE_FRAC_BITS);

    logic                           r_valid;
    logic [1:0][DATA_WIDTH-1:0]     r_x, r_y, n_x, n_y;
    logic [1:0][ANGLE_W-1:0]        r_z, n_z;

    // one micro-rotation per lane, both updates from the old values
    always_comb begin
        logic                  pos;
        logic [DATA_WIDTH-1:0] xs;
        logic [DATA_WIDTH-1:0] ys;
        for (int l = 0; l < 2; l++) begin
            pos = !i_y[l][DATA_WIDTH-1] && (|i_y[l]);
            xs  = DATA_WIDTH'($signed(i_x[l]) >>> SHIFT);
            ys  = DATA_WIDTH'($signed(i_y[l]) >>> SHIFT);
            if (pos) begin
                n_x[l] = i_x[l] + ys;
                n_y[l] = i_y[l] - xs;
                n_z[l] = i_z[l] + K;
            end else begin
                n_x[l] = i_x[l] - ys;
                n_y[l] = i_y[l] + xs;
                n_z[l] = i_z[l] - K;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_z <= n_z;
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;

endmodule

`default_nettype wire

### src/dual_cordic_vectoring_unit.sv
`default_nettype none

// channel     | ports                                    | handshake
// ------------+------------------------------------------+-----------------------------
// command     | i_x_a, i_y_a, i_x_b, i_y_b               | start high, busy low
// result      | o_mag_a, o_resid_a, o_angle_a,           | o_valid high for one cycle
//             | o_mag_b, o_resid_b, o_angle_b            |
//
// one transaction enters every cycle; each cordic iteration is its own register stage
// busy is never raised: the iteration chain has no carried state and nothing stalls it
// the receiver cannot stall; each result is shown for exactly one cycle
// synchronous active-low reset clears only the stage valid bits; data flows unreset

module dual_cordic_vectoring_unit import dcv_pkg::*; #(
    parameter int ITERATIONS      = ITERATIONS_DEF,
    parameter int DATA_WIDTH      = DATA_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic signed [PORT_W-1:0] i_x_a,
    input  wire logic signed [PORT_W-1:0] i_y_a,
    input  wire logic signed [PORT_W-1:0] i_x_b,
    input  wire logic signed [PORT_W-1:0] i_y_b,
    output logic                          o_valid,
    output logic signed [PORT_W-1:0]      o_mag_a,
    output logic signed [PORT_W-1:0]      o_resid_a,
    output logic signed [ANGLE_W-1:0]     o_angle_a,
    output logic signed [PORT_W-1:0]      o_mag_b,
    output logic signed [PORT_W-1:0]      o_resid_b,
    output logic signed [ANGLE_W-1:0]     o_angle_b
);

    // stage k feeds stage k+1; index 0 is the command as it enters
    logic [ITERATIONS:0]                       st_valid;
    logic [ITERATIONS:0][1:0][DATA_WIDTH-1:0]  st_x;
    logic [ITERATIONS:0][1:0][DATA_WIDTH-1:0]  st_y;
    logic [ITERATIONS:0][1:0][ANGLE_W-1:0]     st_z;

    // the pipeline never holds anything back
    assign busy        = 1'b0;
    assign st_valid[0] = start && !busy;
    assign st_z[0]     = '0;

    // fit the 16-bit port values to the datapath width (sign extend or wrap)
    generate
        if (DATA_WIDTH >= PORT_W) begin : g_in_ext
            assign st_x[0][0] = DATA_WIDTH'(i_x_a);
            assign st_y[0][0] = DATA_WIDTH'(i_y_a);
            assign st_x[0][1] = DATA_WIDTH'(i_x_b);
            assign st_y[0][1] = DATA_WIDTH'(i_y_b);
        end else begin : g_in_wrap
            assign st_x[0][0] = i_x_a[DATA_WIDTH-1:0];
            assign st_y[0][0] = i_y_a[DATA_WIDTH-1:0];
            assign st_x[0][1] = i_x_b[DATA_WIDTH-1:0];
            assign st_y[0][1] = i_y_b[DATA_WIDTH-1:0];
        end
    endgenerate

    // one registered micro-rotation per iteration, both lanes side by side
    generate
        for (genvar k = 0; k < ITERATIONS; k++) begin : g_stage
            dcv_stage #(
                .DATA_WIDTH      (DATA_WIDTH),
                .SHIFT           (k),
                .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
            ) u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (st_valid[k]),
                .i_x     (st_x[k]),
                .i_y     (st_y[k]),
                .i_z     (st_z[k]),
                .o_valid (st_valid[k+1]),
                .o_x     (st_x[k+1]),
                .o_y     (st_y[k+1]),
                .o_z     (st_z[k+1])
            );
        end
    endgenerate

    // last stage registers drive the result ports directly
    assign o_valid   = st_valid[ITERATIONS];
    assign o_angle_a = st_z[ITERATIONS][0];
    assign o_angle_b = st_z[ITERATIONS][1];

    // low 16 bits of the final values; a narrow datapath is sign extended
    generate
        if (DATA_WIDTH >= PORT_W) begin : g_out_cut
            assign o_mag_a   = st_x[ITERATIONS][0][PORT_W-1:0];
            assign o_resid_a = st_y[ITERATIONS][0][PORT_W-1:0];
            assign o_mag_b   = st_x[ITERATIONS][1][PORT_W-1:0];
            assign o_resid_b = st_y[ITERATIONS][1][PORT_W-1:0];
        end else begin : g_out_ext
            assign o_mag_a   = PORT_W'($signed(st_x[ITERATIONS][0]));
            assign o_resid_a = PORT_W'($signed(st_y[ITERATIONS][0]));
            assign o_mag_b   = PORT_W'($signed(st_x[ITERATIONS][1]));
            assign o_resid_b = PORT_W'($signed(st_y[ITERATIONS][1]));
        end
    endgenerate

endmodule

`default_nettype wire

### verif/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcv_pkg::*;

    // run length and watchdog
    localparam int unsigned RANDOM_PAIRS = 1600;
    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int unsigned DRAIN_CYCLES = ITERATIONS_DEF + 8;

    // one lane of a result: final x, residual y, accumulated angle
    typedef struct packed {
        logic signed [PORT_W-1:0]  mag;
        logic signed [PORT_W-1:0]  resid;
        logic signed [ANGLE_W-1:0] angle;
    } polar_t;

    // both lanes of one expected transaction
    typedef struct packed {
        polar_t a;
        polar_t b;
    } polar_pair_t;

    // scoreboard: predicts each accepted command and matches results in order
    class polar_scoreboard;
        // atan(2^-i) in q2.13, rounded to nearest
        logic signed [ANGLE_W-1:0] atan_q13 [16] = '{
            16'sd6434, 16'sd3798, 16'sd2007, 16'sd1019,
            16'sd511,  16'sd256,  16'sd128,  16'sd64,
            16'sd32,   16'sd16,   16'sd8,    16'sd4,
            16'sd2,    16'sd1,    16'sd0,    16'sd0
        };
        polar_pair_t expected_polar [$];
        int unsigned mismatch_cnt;

        function new();
            mismatch_cnt = 0;
        endfunction

        // rotate (x,y) onto the positive x axis, tracking the angle
        function polar_t rotate_to_axis(logic signed [PORT_W-1:0] x0,
                                        logic signed [PORT_W-1:0] y0);
            logic signed [PORT_W-1:0]  x;
            logic signed [PORT_W-1:0]  y;
            logic signed [PORT_W-1:0]  x_sh;
            logic signed [PORT_W-1:0]  y_sh;
            logic signed [ANGLE_W-1:0] z;
            polar_t                    res;
            x = x0;
            y = y0;
            z = '0;
            for (int i = 0; i < ITERATIONS_DEF; i++) begin
                x_sh = x >>> i;
                y_sh = y >>> i;
                // zero y counts as not positive
                if (y > 16'sd0) begin
                    x = x + y_sh;
                    y = y - x_sh;
                    z = z + atan_q13[i];
                end else begin
                    x = x - y_sh;
                    y = y + x_sh;
                    z = z - atan_q13[i];
                end
            end
            res.mag   = x;
            res.resid = y;
            res.angle = z;
            return res;
        endfunction

        function void note_command(logic signed [PORT_W-1:0] xa, logic signed [PORT_W-1:0] ya,
                                   logic signed [PORT_W-1:0] xb, logic signed [PORT_W-1:0] yb);
            polar_pair_t p;
            p.a = rotate_to_axis(xa, ya);
            p.b = rotate_to_axis(xb, yb);
            expected_polar.push_back(p);
        endfunction

        function void compare_field(string name, logic signed [15:0] exp_v,
                                    logic signed [15:0] act_v);
            if (exp_v !== act_v) begin
                mismatch_cnt++;
                $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(polar_pair_t act);
            polar_pair_t exp_p;
            if (expected_polar.size() == 0) begin
                mismatch_cnt++;
                $display("%0t unexpected result: expected none actual a=(%0d,%0d,%0d) b=(%0d,%0d,%0d)",
                         $time, act.a.mag, act.a.resid, act.a.angle,
                         act.b.mag, act.b.resid, act.b.angle);
                return;
            end
            exp_p = expected_polar.pop_front();
            compare_field("mag_a",   exp_p.a.mag,   act.a.mag);
            compare_field("resid_a", exp_p.a.resid, act.a.resid);
            compare_field("angle_a", exp_p.a.angle, act.a.angle);
            compare_field("mag_b",   exp_p.b.mag,   act.b.mag);
            compare_field("resid_b", exp_p.b.resid, act.b.resid);
            compare_field("angle_b", exp_p.b.angle, act.b.angle);
        endfunction

        function int unsigned pending();
            return expected_polar.size();
        endfunction
    endclass

    // clock, reset and dut signals
    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic signed [PORT_W-1:0]  i_x_a;
    logic signed [PORT_W-1:0]  i_y_a;
    logic signed [PORT_W-1:0]  i_x_b;
    logic signed [PORT_W-1:0]  i_y_b;
    logic                      o_valid;
    logic signed [PORT_W-1:0]  o_mag_a;
    logic signed [PORT_W-1:0]  o_resid_a;
    logic signed [ANGLE_W-1:0] o_angle_a;
    logic signed [PORT_W-1:0]  o_mag_b;
    logic signed [PORT_W-1:0]  o_resid_b;
    logic signed [ANGLE_W-1:0] o_angle_b;

    // bookkeeping
    polar_scoreboard sb;
    int unsigned     cmd_count;
    int unsigned     cycle_cnt;
    int unsigned     burst_left;

    // values at the edges of the signed range
    localparam logic signed [15:0] CORNER_VALS [8] = '{
        -16'sd32768, -16'sd32767, -16'sd1, 16'sd0,
        16'sd1, 16'sd32766, 16'sd32767, -16'sd16384
    };

    dual_cordic_vectoring_unit uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_x_a     (i_x_a),
        .i_y_a     (i_y_a),
        .i_x_b     (i_x_b),
        .i_y_b     (i_y_b),
        .o_valid   (o_valid),
        .o_mag_a   (o_mag_a),
        .o_resid_a (o_resid_a),
        .o_angle_a (o_angle_a),
        .o_mag_b   (o_mag_b),
        .o_resid_b (o_resid_b),
        .o_angle_b (o_angle_b)
    );

    always #1 i_clk = ~i_clk;

    // watchdog: a hung pipeline or a lost handshake ends the run here
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d transactions outstanding",
                     cycle_cnt, sb.pending());
            $display("Regression FAIL");
            $finish;
        end
    end

    // one sampling process for both sides: the command is noted before the
    // result is checked, so even a path with no register in it stays in order
    always @(posedge i_clk) begin
        polar_pair_t seen;
        if (i_rst_n && start && !busy) begin
            sb.note_command(i_x_a, i_y_a, i_x_b, i_y_b);
            cmd_count++;
        end
        if (i_rst_n && o_valid) begin
            seen.a.mag   = o_mag_a;
            seen.a.resid = o_resid_a;
            seen.a.angle = o_angle_a;
            seen.b.mag   = o_mag_b;
            seen.b.resid = o_resid_b;
            seen.b.angle = o_angle_b;
            sb.check_result(seen);
        end
    end

    // idle time before the next command: mostly none or short, a few long,
    // and now and then a back-to-back burst
    function automatic int unsigned idle_cycles();
        int unsigned r;
        if (burst_left != 0) begin
            burst_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // random vector component: mostly full range, plus small, corner and zero
    function automatic logic signed [15:0] pick_component();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6) return 16'($urandom);
        if (r < 8) return 16'($signed($urandom_range(0, 256)) - 128);
        if (r < 9) return CORNER_VALS[$urandom_range(0, 7)];
        return 16'sd0;
    endfunction

    // drive one command at the falling edge and hold it until it is taken
    task automatic send_pair(input logic signed [15:0] xa, input logic signed [15:0] ya,
                             input logic signed [15:0] xb, input logic signed [15:0] yb);
        int unsigned gap;
        int unsigned taken_before;
        gap = idle_cycles();
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start <= 1'b1;
        i_x_a <= xa;
        i_y_a <= ya;
        i_x_b <= xb;
        i_y_b <= yb;
        taken_before = cmd_count;
        do @(negedge i_clk); while (cmd_count == taken_before);
    endtask

    initial begin
        sb         = new();
        cmd_count  = 0;
        cycle_cnt  = 0;
        burst_left = 0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_x_a      = '0;
        i_y_a      = '0;
        i_x_b      = '0;
        i_y_b      = '0;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: zero vectors, zero y with either sign of x, range extremes
        send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
        send_pair(16'sd32767, 16'sd0, -16'sd32768, 16'sd0);
        send_pair(16'sd0, 16'sd32767, 16'sd0, -16'sd32768);
        send_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
        send_pair(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
        send_pair(-16'sd32768, -16'sd32768, -16'sd32768, 16'sd32767);
        send_pair(16'sd1, 16'sd1, -16'sd1, -16'sd1);
        send_pair(16'sd1, 16'sd0, -16'sd1, 16'sd0);
        send_pair(16'sd0, 16'sd1, 16'sd0, -16'sd1);
        send_pair(-16'sd1, 16'sd0, 16'sd0, -16'sd1);
        send_pair(16'sd100, 16'sd0, -16'sd100, 16'sd1);
        send_pair(16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384);
        send_pair(16'sd1000, -16'sd2000, -16'sd3000, 16'sd4000);
        send_pair(16'sd32767, -16'sd1, -16'sd1, 16'sd32767);
        send_pair(-16'sd32767, 16'sd1, 16'sd5, -16'sd32767);
        send_pair(16'sd23170, 16'sd23170, -16'sd23170, -16'sd23170);

        // random: independent lanes, each component from a weighted mix
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            send_pair(pick_component(), pick_component(),
                      pick_component(), pick_component());
        end
        start <= 1'b0;

        // drain the pipeline, then give a late or extra result time to show
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (sb.pending() != 0)
            $display("%0t %0d expected transactions never arrived", $time, sb.pending());
        if (sb.mismatch_cnt == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire

### files.f
src/dcv_pkg.sv
src/dcv_stage.sv
src/dual_cordic_vectoring_unit.sv
verif/tb_top.sv
